FILE: sv/ppue_pkg.sv
package ppue_pkg;

  localparam int MAX_PARTICLES_DEF = 256;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_EMIT = 2'd1,
    CMD_READ = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK_RD,
    ST_TICK_WAIT,
    ST_TICK_MUL,
    ST_TICK_ADD,
    ST_TICK_WR,
    ST_EMIT_SCAN,
    ST_READ_RD,
    ST_READ_WAIT,
    ST_OUT
  } state_t;

  // Per-slot record as held in the slot memory.
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] life;
    logic [47:0]        color;
    logic [30:0]        size;
  } slot_rec_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

FILE: sv/ppue_step_unit.sv
// Shared per-axis step unit: one multiply of velocity by dt, then a floor
// shift, saturated add into position, one axis at a time.
module ppue_step_unit (
  input  logic               clk,
  input  logic signed [31:0] vel,
  input  logic [30:0]        dt,
  input  logic signed [31:0] pos,
  output logic signed [31:0] new_pos
);

  logic signed [63:0] prod;
  logic signed [31:0] pos_q;
  logic signed [47:0] step;
  logic signed [48:0] sum;

  always_ff @(posedge clk) begin
    prod  <= vel * $signed({1'b0, dt});
    pos_q <= pos;
  end

  // Arithmetic shift floors toward minus infinity.
  assign step = 48'(prod >>> 16);
  assign sum  = 49'(step) + 49'(pos_q);

  always_comb begin
    if (sum > 49'sh0_7FFF_FFFF) begin
      new_pos = 32'sh7FFF_FFFF;
    end else if (sum < -49'sh0_8000_0000) begin
      new_pos = 32'sh8000_0000;
    end else begin
      new_pos = sum[31:0];
    end
  end

endmodule

FILE: sv/particle_pool_update_emit_core.sv
// A tick visits all MAX_PARTICLES slots; an active slot is read, loaded, stepped through three
// multiply/add pairs and written back, while an inactive slot is only skipped. An emit scans
// slots from the hint, wrapping once to the start of the pool; a read fetches one slot and a
// no-op goes straight to output. The result is then held until taken. One item at a time,
// set by the shared step unit and the slot memory. Reset clears active flags, hint and count.
module particle_pool_update_emit_core #(
  parameter int MAX_PARTICLES = ppue_pkg::MAX_PARTICLES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // s_tdata: cmd[1:0], time_value[32:2], pos_x[64:33], pos_y[96:65],
  // pos_z[128:97], vel_x[160:129], vel_y[192:161], vel_z[224:193],
  // color_packed[272:225], particle_size[303:273], count[312:304], slot[320:313]
  input  logic [327:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tdata: active_count[8:0], emitted_count[17:9], slot_active[18],
  // out_pos_x[50:19], out_pos_y[82:51], out_pos_z[114:83], out_vel_x[146:115],
  // out_vel_y[178:147], out_vel_z[210:179], out_lifetime[242:211],
  // out_color[290:243], out_size[321:291]
  output logic [327:0] m_tdata
);

  localparam int IW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW = $clog2(MAX_PARTICLES + 1);

  ppue_pkg::state_t state, state_next;

  // Input item fields, captured at the accepting transfer.
  logic [1:0]  in_cmd;
  logic [30:0] in_time;
  ppue_pkg::slot_rec_t in_rec;
  logic [8:0]  in_count;
  logic [7:0]  in_slot;

  logic [MAX_PARTICLES-1:0] active;
  logic [CW-1:0] hint;
  logic [CW-1:0] live;
  logic [CW-1:0] idx;        // slot walker
  logic [8:0]    emitted;
  logic          wrapped;
  logic [1:0]    axis;

  // Slot memory: one read and one write port.
  ppue_pkg::slot_rec_t mem [MAX_PARTICLES];
  ppue_pkg::slot_rec_t rd_data;
  ppue_pkg::slot_rec_t work;
  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  ppue_pkg::slot_rec_t mem_wdata;
  logic [IW-1:0]       mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // Shared step unit, fed one axis at a time.
  logic signed [31:0] su_vel, su_pos, su_new;
  ppue_step_unit u_step (
    .clk(clk), .vel(su_vel), .dt(in_time), .pos(su_pos), .new_pos(su_new)
  );

  always_comb begin
    unique case (axis)
      2'd0:    begin su_vel = work.vel_x; su_pos = work.pos_x; end
      2'd1:    begin su_vel = work.vel_y; su_pos = work.pos_y; end
      default: begin su_vel = work.vel_z; su_pos = work.pos_z; end
    endcase
  end

  logic idx_in_range;
  logic [IW-1:0] idx_s;
  logic [IW-1:0] slot_idx;
  logic signed [31:0] life_next;
  assign idx_in_range = (idx < CW'(MAX_PARTICLES));
  assign idx_s        = idx[IW-1:0];
  assign slot_idx     = IW'(in_slot);
  assign life_next    = ppue_pkg::sat32(34'(work.life) - 34'($signed({1'b0, in_time})));

  logic emit_done_now;
  assign emit_done_now = (9'(emitted) == in_count);

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = idx_s;
    mem_wdata  = work;
    mem_raddr  = idx_s;
    s_tready   = (state == ppue_pkg::ST_IDLE);
    m_tvalid   = (state == ppue_pkg::ST_OUT);
    unique case (state)
      ppue_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          unique case (ppue_pkg::cmd_t'(s_tdata[1:0]))
            ppue_pkg::CMD_TICK: state_next = ppue_pkg::ST_TICK_RD;
            ppue_pkg::CMD_EMIT: state_next = ppue_pkg::ST_EMIT_SCAN;
            ppue_pkg::CMD_READ: state_next = ppue_pkg::ST_READ_RD;
            default:            state_next = ppue_pkg::ST_OUT;
          endcase
        end
      end
      ppue_pkg::ST_TICK_RD: begin
        if (!idx_in_range) begin
          state_next = ppue_pkg::ST_OUT;
        end else if (active[idx_s]) begin
          state_next = ppue_pkg::ST_TICK_WAIT;
        end
      end
      ppue_pkg::ST_TICK_WAIT: state_next = ppue_pkg::ST_TICK_MUL;
      ppue_pkg::ST_TICK_MUL:  state_next = ppue_pkg::ST_TICK_ADD;
      ppue_pkg::ST_TICK_ADD: begin
        state_next = (axis == 2'd2) ? ppue_pkg::ST_TICK_WR : ppue_pkg::ST_TICK_MUL;
      end
      ppue_pkg::ST_TICK_WR: begin
        mem_we     = 1'b1;
        mem_wdata  = work;
        mem_wdata.life = life_next;
        state_next = ppue_pkg::ST_TICK_RD;
      end
      ppue_pkg::ST_EMIT_SCAN: begin
        if (emit_done_now) begin
          state_next = ppue_pkg::ST_OUT;
        end else if (!idx_in_range) begin
          if (wrapped) state_next = ppue_pkg::ST_OUT;
        end else if (!active[idx_s]) begin
          mem_we    = 1'b1;
          mem_wdata = in_rec;
        end
      end
      ppue_pkg::ST_READ_RD: begin
        mem_raddr  = slot_idx;
        state_next = ppue_pkg::ST_READ_WAIT;
      end
      ppue_pkg::ST_READ_WAIT: state_next = ppue_pkg::ST_OUT;
      ppue_pkg::ST_OUT: begin
        if (m_tready) state_next = ppue_pkg::ST_IDLE;
      end
      default: state_next = ppue_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppue_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  logic read_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= '0;
      hint    <= '0;
      live    <= '0;
      idx     <= '0;
      emitted <= '0;
      wrapped <= 1'b0;
      axis    <= '0;
      read_hit <= 1'b0;
    end else begin
      unique case (state)
        ppue_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            in_cmd   <= s_tdata[1:0];
            in_time  <= s_tdata[32:2];
            in_rec.pos_x <= s_tdata[64:33];
            in_rec.pos_y <= s_tdata[96:65];
            in_rec.pos_z <= s_tdata[128:97];
            in_rec.vel_x <= s_tdata[160:129];
            in_rec.vel_y <= s_tdata[192:161];
            in_rec.vel_z <= s_tdata[224:193];
            in_rec.life  <= {1'b0, s_tdata[32:2]};
            in_rec.color <= s_tdata[272:225];
            in_rec.size  <= s_tdata[303:273];
            in_count <= s_tdata[312:304];
            in_slot  <= s_tdata[320:313];
            emitted  <= '0;
            wrapped  <= 1'b0;
            read_hit <= 1'b0;
            idx      <= (ppue_pkg::cmd_t'(s_tdata[1:0]) == ppue_pkg::CMD_EMIT) ? hint : '0;
          end
        end
        ppue_pkg::ST_TICK_RD: begin
          if (idx_in_range && !active[idx_s]) idx <= idx + 1'b1;
          axis <= '0;
        end
        ppue_pkg::ST_TICK_WAIT: work <= rd_data;
        ppue_pkg::ST_TICK_ADD: begin
          unique case (axis)
            2'd0:    work.pos_x <= su_new;
            2'd1:    work.pos_y <= su_new;
            default: work.pos_z <= su_new;
          endcase
          axis <= axis + 2'd1;
        end
        ppue_pkg::ST_TICK_WR: begin
          if (life_next <= 0) begin
            active[idx_s] <= 1'b0;
            if (live != '0) live <= live - 1'b1;
            if (idx < hint) hint <= idx;
          end
          idx <= idx + 1'b1;
        end
        ppue_pkg::ST_EMIT_SCAN: begin
          if (emit_done_now) begin
            hint <= idx;
          end else if (!idx_in_range) begin
            if (wrapped) begin
              hint <= idx;
            end else begin
              wrapped <= 1'b1;
              idx     <= '0;
            end
          end else if (!active[idx_s]) begin
            active[idx_s] <= 1'b1;
            live    <= live + 1'b1;
            emitted <= emitted + 9'd1;
            idx     <= idx + 1'b1;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ppue_pkg::ST_READ_RD: begin
          read_hit <= (32'(in_slot) < MAX_PARTICLES) && active[slot_idx];
        end
        ppue_pkg::ST_READ_WAIT: work <= rd_data;
        default: ;
      endcase
    end
  end

  logic show;
  assign show = (ppue_pkg::cmd_t'(in_cmd) == ppue_pkg::CMD_READ) && read_hit;

  always_comb begin
    m_tdata = '0;
    m_tdata[8:0]  = 9'(live);
    m_tdata[17:9] = (ppue_pkg::cmd_t'(in_cmd) == ppue_pkg::CMD_EMIT) ? emitted : 9'd0;
    if (show) begin
      m_tdata[18]      = 1'b1;
      m_tdata[50:19]   = work.pos_x;
      m_tdata[82:51]   = work.pos_y;
      m_tdata[114:83]  = work.pos_z;
      m_tdata[146:115] = work.vel_x;
      m_tdata[178:147] = work.vel_y;
      m_tdata[210:179] = work.vel_z;
      m_tdata[242:211] = work.life;
      m_tdata[290:243] = work.color;
      m_tdata[321:291] = work.size;
    end
  end

endmodule

FILE: sv/ppue_checker.sv
module ppue_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [327:0] m_tdata
);

  // Never ready for a new item while a result is pending.
  a_excl: assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("ready while result pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped while stalled");

  a_cnt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[8:0] <= 9'd256)
    else $error("active count out of range");

  a_emit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[18] |-> m_tdata[17:9] == 9'd0)
    else $error("read result with emit count");

  a_rel: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready |=> s_tready)
    else $error("not ready after result transfer");

endmodule

bind particle_pool_update_emit_core ppue_checker u_chk (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

FILE: test/tb_top.sv
module tb_top;
  import ppue_pkg::*;

  localparam int NSLOT = 256;
  localparam int RANDOM_ITEMS = 1000;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  // s_tdata: cmd, time_value, pos_x/y/z, vel_x/y/z, color_packed, particle_size, count, slot
  logic [327:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  // m_tdata: active_count, emitted_count, slot_active, out_pos_x/y/z, out_vel_x/y/z,
  // out_lifetime, out_color, out_size
  logic [327:0] m_tdata;

  typedef struct packed {
    logic [7:0]         slot;
    logic [8:0]         count;
    logic [30:0]        psize;
    logic [47:0]        color;
    logic signed [31:0] vel_z;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
    logic [30:0]        tval;
    cmd_t               cmd;
  } pool_cmd_t;

  typedef struct packed {
    logic [30:0]        size;
    logic [47:0]        color;
    logic signed [31:0] life;
    logic signed [31:0] vel_z;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
    logic               slot_active;
    logic [8:0]         emitted;
    logic [8:0]         active;
  } pool_resp_t;

  // Predicts the pool contents and checks every response in order.
  class pool_scoreboard;
    bit              live[NSLOT];
    slot_rec_t       rec[NSLOT];
    int unsigned     hint;
    int unsigned     total;
    pool_resp_t      pending[$];
    int              errors;
    int              n_resp;
    int              n_emitted;

    function new();
      hint = 0;
      total = 0;
      errors = 0;
      n_resp = 0;
      n_emitted = 0;
      foreach (live[i]) live[i] = 1'b0;
    endfunction

    function logic signed [31:0] clamp(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    // Position step: floor(vel * dt / 2^16), then saturating add.
    function logic signed [31:0] move(logic signed [31:0] p, logic signed [31:0] v,
                                      logic [30:0] dt);
      longint prod;
      prod = longint'(v) * longint'({33'd0, dt});
      return clamp(longint'(p) + (prod >>> 16));
    endfunction

    function int unsigned next_free(int unsigned from);
      while (from < NSLOT && live[from]) from++;
      return from;
    endfunction

    function void note_input(pool_cmd_t c);
      pool_resp_t r;
      r = '0;
      case (c.cmd)
        CMD_TICK: begin
          for (int i = 0; i < NSLOT; i++) begin
            if (live[i]) begin
              rec[i].pos_x = move(rec[i].pos_x, rec[i].vel_x, c.tval);
              rec[i].pos_y = move(rec[i].pos_y, rec[i].vel_y, c.tval);
              rec[i].pos_z = move(rec[i].pos_z, rec[i].vel_z, c.tval);
              rec[i].life = clamp(longint'(rec[i].life) - longint'({33'd0, c.tval}));
              if (rec[i].life <= 0) begin
                live[i] = 1'b0;
                if (total > 0) total--;
                if (i < hint) hint = i;
              end
            end
          end
        end
        CMD_EMIT: begin
          for (int k = 0; k < c.count; k++) begin
            hint = next_free(hint);
            if (hint >= NSLOT) begin
              hint = next_free(0);
              if (hint >= NSLOT) break;
            end
            rec[hint].pos_x = c.pos_x;
            rec[hint].pos_y = c.pos_y;
            rec[hint].pos_z = c.pos_z;
            rec[hint].vel_x = c.vel_x;
            rec[hint].vel_y = c.vel_y;
            rec[hint].vel_z = c.vel_z;
            rec[hint].life = {1'b0, c.tval};
            rec[hint].color = c.color;
            rec[hint].size = c.psize;
            live[hint] = 1'b1;
            total++;
            r.emitted++;
            hint++;
          end
          n_emitted += r.emitted;
        end
        CMD_READ: begin
          if (live[c.slot]) begin
            r.slot_active = 1'b1;
            r.pos_x = rec[c.slot].pos_x;
            r.pos_y = rec[c.slot].pos_y;
            r.pos_z = rec[c.slot].pos_z;
            r.vel_x = rec[c.slot].vel_x;
            r.vel_y = rec[c.slot].vel_y;
            r.vel_z = rec[c.slot].vel_z;
            r.life = rec[c.slot].life;
            r.color = rec[c.slot].color;
            r.size = rec[c.slot].size;
          end
        end
        default: ;
      endcase
      r.active = total[8:0];
      pending.push_back(r);
    endfunction

    function void compare(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(pool_resp_t a);
      pool_resp_t e;
      n_resp++;
      if (pending.size() == 0) begin
        $error("unexpected result transfer: %0h", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      compare("active_count", 64'(e.active), 64'(a.active));
      compare("emitted_count", 64'(e.emitted), 64'(a.emitted));
      compare("slot_active", 64'(e.slot_active), 64'(a.slot_active));
      compare("out_pos_x", 64'(e.pos_x), 64'(a.pos_x));
      compare("out_pos_y", 64'(e.pos_y), 64'(a.pos_y));
      compare("out_pos_z", 64'(e.pos_z), 64'(a.pos_z));
      compare("out_vel_x", 64'(e.vel_x), 64'(a.vel_x));
      compare("out_vel_y", 64'(e.vel_y), 64'(a.vel_y));
      compare("out_vel_z", 64'(e.vel_z), 64'(a.vel_z));
      compare("out_lifetime", 64'(e.life), 64'(a.life));
      compare("out_color", 64'(e.color), 64'(a.color));
      compare("out_size", 64'(e.size), 64'(a.size));
    endfunction
  endclass

  pool_scoreboard sb;
  int             burst_left;
  int             n_sent;

  particle_pool_update_emit_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Receiver stalls in an irregular pattern, with long stretches of no stalls.
  int stall_phase;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if ((stall_phase / 400) % 3 == 2) m_tready <= 1'b1;
      else m_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(pool_resp_t'(m_tdata[321:0]));
  end

  function automatic logic [31:0] edge_val();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic pool_cmd_t random_item(cmd_t c);
    pool_cmd_t it;
    it.cmd = c;
    it.pos_x = edge_val();
    it.pos_y = edge_val();
    it.pos_z = edge_val();
    it.vel_x = ($urandom_range(0, 1)) ? edge_val() : $signed($urandom_range(0, 2**20)) - 2**19;
    it.vel_y = edge_val();
    it.vel_z = edge_val();
    it.color = 48'({$urandom(), $urandom()});
    it.psize = 31'($urandom());
    it.slot = 8'($urandom());
    case (c)
      CMD_TICK: it.tval = ($urandom_range(0, 9) == 0) ? 31'($urandom())
                                                      : 31'($urandom_range(0, 32'h3_0000));
      CMD_EMIT: it.tval = ($urandom_range(0, 9) == 0) ? 31'($urandom())
                                                      : 31'($urandom_range(0, 32'h8_0000));
      default:  it.tval = 31'($urandom());
    endcase
    // Mostly small emits so ticks stay short; now and then a large one.
    it.count = ($urandom_range(0, 19) == 0) ? 9'($urandom_range(0, 300))
                                            : 9'($urandom_range(0, 12));
    return it;
  endfunction

  // Sends one item, honoring the burst and gap pattern of the sender.
  task automatic send_item(pool_cmd_t it);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, it};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(it);
    n_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    pool_cmd_t it;
    sb = new();
    burst_left = 0;
    n_sent = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty pool, all commands, extremes, overflow and saturation.
    it = random_item(CMD_READ);  it.slot = 8'd0;   send_item(it);
    it = random_item(CMD_NOP);   send_item(it);
    it = random_item(CMD_TICK);  it.tval = 31'h7FFF_FFFF; send_item(it);
    it = random_item(CMD_EMIT);  it.count = 9'd0;  send_item(it);
    it = random_item(CMD_EMIT);  it.count = 9'd2;  it.tval = 31'd0;
    it.pos_x = 32'sh7FFF_FFF0; it.vel_x = 32'sh7FFF_FFFF;
    it.pos_y = 32'sh8000_0010; it.vel_y = 32'sh8000_0000;
    it.pos_z = 32'sh0; it.vel_z = -32'sd1; send_item(it);
    it = random_item(CMD_READ);  it.slot = 8'd1;   send_item(it);
    it = random_item(CMD_TICK);  it.tval = 31'd1;  send_item(it);
    it = random_item(CMD_READ);  it.slot = 8'd0;   send_item(it);
    it = random_item(CMD_EMIT);  it.count = 9'd3;  it.tval = 31'h7FFF_FFFF;
    it.pos_x = 32'sh7FFF_FFF0; it.vel_x = 32'sh7FFF_FFFF; it.vel_y = 32'sh8000_0000;
    it.vel_z = -32'sd1; it.color = '1; it.psize = '1; send_item(it);
    it = random_item(CMD_TICK);  it.tval = 31'h7FFF_FFFF; send_item(it);
    it = random_item(CMD_READ);  it.slot = 8'd2;   send_item(it);
    it = random_item(CMD_EMIT);  it.count = 9'd256; it.tval = 31'h1_0000; send_item(it);
    it = random_item(CMD_EMIT);  it.count = 9'd511; send_item(it);
    it = random_item(CMD_READ);  it.slot = 8'd255; send_item(it);
    it = random_item(CMD_TICK);  it.tval = 31'h8000; send_item(it);
    it = random_item(CMD_READ);  it.slot = 8'd128; send_item(it);
    it = random_item(CMD_TICK);  it.tval = 31'h1_0000; send_item(it);
    it = random_item(CMD_EMIT);  it.count = 9'd300; it.tval = 31'h4_0000; send_item(it);
    it = random_item(CMD_TICK);  it.tval = 31'h7FFF_FFFF; send_item(it);

    // Hold off until the pool has answered everything.
    drain();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2:    it = random_item(CMD_TICK);
        3, 4, 5:    it = random_item(CMD_EMIT);
        6, 7, 8:    it = random_item(CMD_READ);
        default:    it = random_item(CMD_NOP);
      endcase
      send_item(it);
      if (n == RANDOM_ITEMS / 2) drain();
    end

    drain();
    repeat (2 * NSLOT * 6) @(posedge clk);
    $display("Ran %0d commands (%0d results checked) covering tick, emit, read and idle;",
             n_sent, sb.n_resp);
    $display("emits placed %0d particles in total, including pool-full wraps.", sb.n_emitted);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("particle_pool_update_emit_core verification clean");
    end else begin
      $display("particle_pool_update_emit_core verification failed");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("particle_pool_update_emit_core verification failed");
    $finish;
  end

endmodule

FILE: sim.f
sv/ppue_pkg.sv
sv/ppue_step_unit.sv
sv/particle_pool_update_emit_core.sv
sv/ppue_checker.sv
test/tb_top.sv
